// ===== rtl/core/tftpw_pkg.sv =====
package tftpw_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  // Configuration register indexes (paddr[2])
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  localparam int unsigned HDR_LEN     = 4;
  localparam logic [7:0]  DATA_OPCODE = 8'h03;

  localparam logic [9:0]  BLOCK_SIZE_RST  = 10'd512;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd50;
  localparam logic [7:0]  POLL_MAX        = 8'hFF;

  // Queue depth between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Everything one input item causes: an optional payload beat and an
  // optional closing beat (ack, completing ack or abort).
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data;
    logic        has_tail;
    kind_e       tail_kind;
    logic [15:0] tail_blk;
    logic [7:0]  sum;
    logic [7:0]  xsum;
  } entry_t;

endpackage

// ===== rtl/core/tftpw_chan_if.sv =====
// Input channel: one item per beat
interface tftpw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output op, output data_byte, output end_of_datagram,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input end_of_datagram,
                  output ready);
endinterface

// Output channel: one result per beat
interface tftpw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] ack_block;
  logic [7:0]  sum_check;
  logic [7:0]  xor_check;
  logic        run_last;

  modport source (output valid, output kind, output payload_byte, output ack_block,
                  output sum_check, output xor_check, output run_last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input ack_block,
                  input sum_check, input xor_check, input run_last, output ready);
endinterface

// ===== rtl/core/tftpw_front.sv =====
module tftpw_front #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tftpw_in_if.sink            in_i,
  input  logic [9:0]          block_size_i,
  input  logic [7:0]          retry_limit_i,
  input  logic                full_i,
  output logic                push_o,
  output tftpw_pkg::entry_t   entry_o
);

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + tftpw_pkg::HDR_LEN + 1);
  localparam logic [POS_W-1:0] CAP  = POS_W'(MAX_PAYLOAD + tftpw_pkg::HDR_LEN);
  localparam logic [POS_W-1:0] HDR  = POS_W'(tftpw_pkg::HDR_LEN);
  localparam logic [POS_W-1:0] ONE  = POS_W'(1);

  logic             active_q, active_d;
  logic [15:0]      exp_blk_q, exp_blk_d;
  logic [POS_W-1:0] pos_q, pos_d, pos_n;
  logic [7:0]       hdr_hi_q, hdr_hi_d;
  logic             hdr_ok_q, hdr_ok_d, ok_n;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       xsum_q, xsum_d;
  logic [7:0]       polls_q, polls_d;

  logic             acc;
  logic [7:0]       poll_inc;
  logic             poll_abort;
  logic             bs_ok;
  logic [POS_W-1:0] eff_bs;
  tftpw_pkg::entry_t ent;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;

  // Shared poll step and effective block size
  assign poll_inc   = (polls_q != tftpw_pkg::POLL_MAX) ? polls_q + 8'd1 : polls_q;
  assign poll_abort = (poll_inc >= retry_limit_i);
  assign bs_ok      = (block_size_i != 10'd0) && ({1'b0, block_size_i} <= 11'(MAX_PAYLOAD));
  assign eff_bs     = bs_ok ? POS_W'(block_size_i) : POS_W'(MAX_PAYLOAD);

  // Classify the item and work out the next state
  always_comb begin
    active_d  = active_q;
    exp_blk_d = exp_blk_q;
    pos_d     = pos_q;
    hdr_hi_d  = hdr_hi_q;
    hdr_ok_d  = hdr_ok_q;
    sum_d     = sum_q;
    xsum_d    = xsum_q;
    polls_d   = polls_q;
    pos_n     = pos_q;
    ok_n      = hdr_ok_q;

    ent.has_byte  = 1'b0;
    ent.data      = in_i.data_byte;
    ent.has_tail  = 1'b0;
    ent.tail_kind = tftpw_pkg::KIND_ACK;
    ent.tail_blk  = '0;

    if (acc) begin
      unique case (tftpw_pkg::op_e'(in_i.op))
        tftpw_pkg::OP_START: begin
          active_d     = 1'b1;
          exp_blk_d    = 16'd1;
          pos_d        = '0;
          hdr_hi_d     = '0;
          hdr_ok_d     = 1'b0;
          sum_d        = '0;
          xsum_d       = '0;
          polls_d      = '0;
          ent.has_tail = 1'b1;
        end
        tftpw_pkg::OP_TICK: begin
          if (active_q) begin
            polls_d = poll_inc;
            if (poll_abort) begin
              active_d      = 1'b0;
              pos_d         = '0;
              hdr_hi_d      = '0;
              hdr_ok_d      = 1'b0;
              ent.has_tail  = 1'b1;
              ent.tail_kind = tftpw_pkg::KIND_ABORT;
            end
          end
        end
        tftpw_pkg::OP_BYTE: begin
          if (active_q) begin
            // Header check and payload, bytes past the cap are dropped
            if (pos_q < CAP) begin
              priority if (pos_q == POS_W'(0)) begin
                ok_n = (in_i.data_byte == 8'h00);
              end else if (pos_q == POS_W'(1)) begin
                ok_n = hdr_ok_q && (in_i.data_byte == tftpw_pkg::DATA_OPCODE);
              end else if (pos_q == POS_W'(2)) begin
                hdr_hi_d = in_i.data_byte;
              end else if (pos_q == POS_W'(3)) begin
                ok_n = hdr_ok_q && ({hdr_hi_q, in_i.data_byte} == exp_blk_q);
              end else begin
                if (hdr_ok_q) begin
                  sum_d        = sum_q + in_i.data_byte;
                  xsum_d       = xsum_q ^ in_i.data_byte;
                  ent.has_byte = 1'b1;
                end
              end
              pos_n = pos_q + ONE;
            end
            pos_d    = pos_n;
            hdr_ok_d = ok_n;

            // End of datagram: ack, complete, or count a poll and abort at the retry limit
            if (in_i.end_of_datagram) begin
              pos_d    = '0;
              hdr_hi_d = '0;
              hdr_ok_d = 1'b0;
              if (pos_n >= HDR && ok_n) begin
                ent.has_tail = 1'b1;
                ent.tail_blk = exp_blk_q;
                if (pos_n == eff_bs + HDR) begin
                  ent.tail_kind = tftpw_pkg::KIND_ACK;
                  exp_blk_d     = exp_blk_q + 16'd1;
                  polls_d       = '0;
                end else begin
                  ent.tail_kind = tftpw_pkg::KIND_DONE;
                  active_d      = 1'b0;
                end
              end else begin
                polls_d = poll_inc;
                if (poll_abort) begin
                  active_d      = 1'b0;
                  ent.has_tail  = 1'b1;
                  ent.tail_kind = tftpw_pkg::KIND_ABORT;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    ent.sum  = sum_d;
    ent.xsum = xsum_d;
  end

  assign push_o  = acc && (ent.has_byte || ent.has_tail);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      exp_blk_q <= 16'd1;
      pos_q     <= '0;
      hdr_hi_q  <= '0;
      hdr_ok_q  <= 1'b0;
      sum_q     <= '0;
      xsum_q    <= '0;
      polls_q   <= '0;
    end else begin
      active_q  <= active_d;
      exp_blk_q <= exp_blk_d;
      pos_q     <= pos_d;
      hdr_hi_q  <= hdr_hi_d;
      hdr_ok_q  <= hdr_ok_d;
      sum_q     <= sum_d;
      xsum_q    <= xsum_d;
      polls_q   <= polls_d;
    end
  end

endmodule

// ===== rtl/core/tftpw_queue.sv =====
module tftpw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tftpw_pkg::entry_t entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output tftpw_pkg::entry_t head_o
);

  localparam int unsigned CNT_W = $clog2(tftpw_pkg::QDEPTH + 1);

  tftpw_pkg::entry_t             mem_q [tftpw_pkg::QDEPTH];
  logic [tftpw_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(tftpw_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tftpw_back.sv =====
module tftpw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  tftpw_pkg::entry_t head_i,
  output logic              pop_o,
  tftpw_out_if.source       out_o
);

  logic phase_q;
  logic byte_beat;
  logic last;
  logic fire;

  // Payload beat goes first, then the closing beat
  assign byte_beat = head_i.has_byte && !phase_q;
  assign last      = !byte_beat || !head_i.has_tail;
  assign fire      = out_o.valid && out_o.ready;
  assign pop_o     = fire && last;

  assign out_o.valid        = !empty_i;
  assign out_o.kind         = byte_beat ? tftpw_pkg::KIND_DATA : head_i.tail_kind;
  assign out_o.payload_byte = byte_beat ? head_i.data : 8'h00;
  assign out_o.ack_block    = byte_beat ? 16'h0000 : head_i.tail_blk;
  assign out_o.sum_check    = head_i.sum;
  assign out_o.xor_check    = head_i.xsum;
  assign out_o.run_last     = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= !last;
    end
  end

endmodule

// ===== rtl/core/tftp_write_receiver_with_check.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    op, data_byte, end_of_datagram
// out_o     out  valid/ready    kind, payload_byte, ack_block, sum_check,
//                               xor_check, run_last
// APB       in   psel/penable   block_size (0x0), retry_limit (0x4)
//
// One item is taken per cycle while the queue is not full; the front
// updates the transfer state in that cycle and queues up to two results
// (a payload beat and a closing beat). The back sends one beat per cycle
// while out_o.ready is high; the four-entry queue absorbs output stalls.
// in_i.ready falls only when the queue is full.
// Reset is asynchronous, active low; no clearing pass is needed.
module tftp_write_receiver_with_check #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tftpw_in_if.sink    in_i,
  tftpw_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0]        block_size_q;
  logic [7:0]        retry_limit_q;
  logic              cfg_wr;
  logic              push, pop, full, empty;
  tftpw_pkg::entry_t entry, head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= tftpw_pkg::BLOCK_SIZE_RST;
      retry_limit_q <= tftpw_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tftpw_pkg::REG_BLOCK_SIZE:  block_size_q  <= pwdata[9:0];
        tftpw_pkg::REG_RETRY_LIMIT: retry_limit_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tftpw_pkg::REG_BLOCK_SIZE:  prdata = {22'd0, block_size_q};
      tftpw_pkg::REG_RETRY_LIMIT: prdata = {24'd0, retry_limit_q};
      default:                    prdata = '0;
    endcase
  end

  tftpw_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .block_size_i  (block_size_q),
    .retry_limit_i (retry_limit_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  tftpw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  tftpw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
